@@ sv/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ sv/dla_pkg.sv @@
// shared types, codes and defaults of the aggregation block
// no dependencies
package dla_pkg;

    // parameter defaults
    localparam int MAX_POINTS_DEF = 16384;
    localparam int COORD_BITS_DEF = 10;

    // fixed field widths
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 15;
    localparam int DIM_CFG_W   = 11;
    localparam int LIMIT_W     = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // commands
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ATTACHED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OCCUPIED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_NBR   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NBR_MODE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_SHAPE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_POINT_LIMIT = 3'd4;

    // configuration reset values
    localparam logic [DIM_CFG_W-1:0] GRID_DIM_RST    = 11'd512;
    localparam logic [LIMIT_W-1:0]   POINT_LIMIT_RST = 15'd10000;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_SCAN,
        ST_SWAIT,
        ST_DECIDE,
        ST_NBR,
        ST_NWAIT,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    // tag that travels with a point through the distance pipe
    typedef struct packed {
        logic vld;
        logic use_pt;
        logic in_snap;
        logic nbr;
        logic last;
    } dla_tag_t;

endpackage

@@ sv/dla_store.sv @@
// point store: single port write, registered read
// depends on nothing
module dla_store #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/dla_dist.sv @@
// two-stage squared distance pipe from the sample to a point
// depends on dla_pkg for the tag type
module dla_dist #(
    parameter int COORD_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dla_pkg::dla_tag_t         in_tag,
    input  logic [COORD_BITS-1:0]     sx,
    input  logic [COORD_BITS-1:0]     sy,
    input  logic [COORD_BITS-1:0]     px,
    input  logic [COORD_BITS-1:0]     py,
    output dla_pkg::dla_tag_t         out_tag,
    output logic [2*COORD_BITS:0]     dist_sq,
    output logic [COORD_BITS-1:0]     out_px,
    output logic [COORD_BITS-1:0]     out_py
);
    import dla_pkg::*;

    localparam int SQW = 2 * COORD_BITS;
    localparam int DDW = 2 * COORD_BITS + 1;

    logic [COORD_BITS-1:0] adx, ady;
    logic [SQW-1:0]        sqx_reg, sqy_reg;
    logic [COORD_BITS-1:0] px1_reg, py1_reg;
    logic [DDW-1:0]        dist_reg;
    logic [COORD_BITS-1:0] px2_reg, py2_reg;
    dla_tag_t              tag1_reg, tag2_reg;

    // absolute differences
    assign adx = (sx >= px) ? (sx - px) : (px - sx);
    assign ady = (sy >= py) ? (sy - py) : (py - sy);

    // tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
        end
    end

    // squares, then sum
    always_ff @(posedge clk)
    begin
        sqx_reg  <= SQW'(adx) * SQW'(adx);
        sqy_reg  <= SQW'(ady) * SQW'(ady);
        px1_reg  <= px;
        py1_reg  <= py;
        dist_reg <= DDW'(sqx_reg) + DDW'(sqy_reg);
        px2_reg  <= px1_reg;
        py2_reg  <= py1_reg;
    end

    assign out_tag = tag2_reg;
    assign dist_sq = dist_reg;
    assign out_px  = px2_reg;
    assign out_py  = py2_reg;

endmodule

@@ sv/aggregation_nearest_attach.sv @@
// top level of the aggregation block: controller, configuration and result register
// depends on dla_pkg, dla_store and dla_dist
//
// Grows a point aggregate kept in one synchronous memory. Frame commands, the
// unused command and refused samples (full, out of range, empty store) go
// straight to the result; a centre seed writes one point, and a bottom-row
// seed makes one memory write per column. An accepted sample reads every
// stored point once through the single read port of the store: one read per
// stored point through the memory and the distance pipe, a decision, then,
// unless the sample hits an occupied point of the frame snapshot, nine neighbour
// candidates through the same distance pipe, a commit and the result load. One item
// is worked on at a time; a new word is taken while the previous result still waits
// in the output register. The store needs no clearing after reset, only entries
// below the count are ever read.
module aggregation_nearest_attach #(
    parameter int MAX_POINTS = dla_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dla_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [dla_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dla_pkg::CFG_DATA_W-1:0]  cfg_data,
    // item channel
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [dla_pkg::CMD_W-1:0]       command,
    input  logic [COORD_BITS-1:0]           sample_x,
    input  logic [COORD_BITS-1:0]           sample_y,
    // result channel
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [dla_pkg::STATUS_W-1:0]    status,
    output logic [COORD_BITS-1:0]           attached_x,
    output logic [COORD_BITS-1:0]           attached_y,
    output logic [dla_pkg::COUNT_OUT_W-1:0] point_count
);
    import dla_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int DW   = COORD_BITS + 1;
    localparam int EW   = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;
    localparam int SW   = (CW > DW) ? CW : DW;
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int DDW  = 2 * COORD_BITS + 1;
    localparam int LW   = 2 * DW + 1;
    localparam int PW   = 2 * COORD_BITS;

    // saturate a grid dimension to 1 .. 2^COORD_BITS
    function automatic logic [DW-1:0] sat_dim(input logic [DIM_CFG_W-1:0] v);
        logic [EW-1:0] ve;
        logic [EW-1:0] top_v;
        ve    = EW'(v);
        top_v = EW'(1) << COORD_BITS;
        if (ve == '0)
            return DW'(1);
        else if (ve > top_v)
            return DW'(top_v);
        else
            return DW'(ve);
    endfunction

    // configuration registers
    logic [DIM_CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic                 nbr_mode_reg, seed_shape_reg;
    logic [LIMIT_W-1:0]   point_limit_reg;

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, snap_reg;
    logic [AW-1:0]   scan_idx_reg;
    logic [1:0]      row_reg, col_reg;
    logic            hit_reg, found_reg;
    logic            result_valid_reg;
    dla_tag_t        tag_d1_reg;

    // payload registers
    logic [COORD_BITS-1:0] sx_reg, sy_reg;
    logic [DDW-1:0]        best_d_reg;
    logic [COORD_BITS-1:0] best_x_reg, best_y_reg;
    logic [LW-1:0]         nlim_reg;
    logic [2*DW-1:0]       area_reg;
    logic [COORD_BITS-1:0] nbest_x_reg, nbest_y_reg;
    logic [COORD_BITS-1:0] cand_x_d1_reg, cand_y_d1_reg;
    logic [STATUS_W-1:0]   res_status_reg, status_reg;
    logic [COORD_BITS-1:0] res_x_reg, res_y_reg, attached_x_reg, attached_y_reg;
    logic [COUNT_OUT_W-1:0] point_count_reg;

    // combinational control
    logic                  accept, out_load;
    logic [DW-1:0]         w_dim, h_dim;
    logic                  is_full, out_of_range, seed_go, scan_last, nbr_last;
    logic                  mem_wr_en, mem_rd_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [PW-1:0]         mem_wr_data, mem_rd_data;
    dla_tag_t              issue_tag, d_tag;
    logic [DW-1:0]         cand_c, cand_r;
    logic                  c_ok, r_ok, cand_use;
    logic [COORD_BITS-1:0] dist_px, dist_py, d_px, d_py;
    logic [DDW-1:0]        d_val;

    assign w_dim = sat_dim(grid_width_reg);
    assign h_dim = sat_dim(grid_height_reg);

    // handshakes
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_load   = (state_reg == ST_FINISH) && (!result_valid_reg || result_ready);

    // sample checks done at acceptance
    assign is_full = (CMPW'(count_reg) >= CMPW'(point_limit_reg))
                  || (count_reg == CW'(MAX_POINTS));
    assign out_of_range = (DW'(sample_x) >= w_dim) || (DW'(sample_y) >= h_dim);
    assign seed_go   = (SW'(count_reg) < SW'(w_dim)) && (count_reg != CW'(MAX_POINTS));
    assign scan_last = (CW'(scan_idx_reg) == (count_reg - CW'(1)));
    assign nbr_last  = (row_reg == 2'd2) && (col_reg == 2'd2);

    // neighbour candidate around the nearest point
    assign cand_c = DW'(best_x_reg) + DW'(col_reg) - DW'(1);
    assign cand_r = DW'(best_y_reg) + DW'(row_reg) - DW'(1);
    always_comb
    begin
        c_ok = 1'b1;
        r_ok = 1'b1;
        if (col_reg == 2'd0)
            c_ok = (best_x_reg != '0);
        else if (col_reg == 2'd2)
            c_ok = (cand_c < w_dim);
        if (row_reg == 2'd0)
            r_ok = (best_y_reg != '0);
        else if (row_reg == 2'd2)
            r_ok = (cand_r < h_dim);
        cand_use = c_ok && r_ok
                && !((row_reg == 2'd1) && (col_reg == 2'd1))
                && !(!nbr_mode_reg && (row_reg != 2'd1) && (col_reg != 2'd1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_START:  state_next = seed_shape_reg ? ST_SEED : ST_FINISH;
                        CMD_SAMPLE: state_next = (is_full || out_of_range || count_reg == '0)
                                               ? ST_FINISH : ST_SCAN;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SEED:   if (!seed_go) state_next = ST_FINISH;
            ST_SCAN:   if (scan_last) state_next = ST_SWAIT;
            ST_SWAIT:  if (d_tag.vld && d_tag.last) state_next = ST_DECIDE;
            ST_DECIDE: state_next = hit_reg ? ST_FINISH : ST_NBR;
            ST_NBR:    if (nbr_last) state_next = ST_NWAIT;
            ST_NWAIT:  if (d_tag.vld && d_tag.last) state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_FINISH;
            ST_FINISH: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs: memory accesses and distance pipe issue
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(count_reg);
        mem_wr_data = {nbest_y_reg, nbest_x_reg};
        mem_rd_en   = 1'b0;
        issue_tag   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_START && !seed_shape_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = '0;
                    mem_wr_data = {COORD_BITS'(h_dim >> 1), COORD_BITS'(w_dim >> 1)};
                end
            end
            ST_SEED:
            begin
                mem_wr_en   = seed_go;
                mem_wr_data = {COORD_BITS'(h_dim - DW'(1)), COORD_BITS'(count_reg)};
            end
            ST_SCAN:
            begin
                mem_rd_en         = 1'b1;
                issue_tag.vld     = 1'b1;
                issue_tag.use_pt  = 1'b1;
                issue_tag.in_snap = (CW'(scan_idx_reg) < snap_reg);
                issue_tag.last    = scan_last;
            end
            ST_NBR:
            begin
                issue_tag.vld    = 1'b1;
                issue_tag.use_pt = cand_use;
                issue_tag.nbr    = 1'b1;
                issue_tag.last   = nbr_last;
            end
            ST_COMMIT: mem_wr_en = found_reg;
            default:   mem_wr_en = 1'b0;
        endcase
    end

    // point store
    dla_store #(
        .DEPTH (MAX_POINTS),
        .WIDTH (PW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (mem_rd_data)
    );

    // distance pipe input: stored point or neighbour candidate
    assign dist_px = tag_d1_reg.nbr ? cand_x_d1_reg : mem_rd_data[COORD_BITS-1:0];
    assign dist_py = tag_d1_reg.nbr ? cand_y_d1_reg : mem_rd_data[PW-1:COORD_BITS];

    dla_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (tag_d1_reg),
        .sx      (sx_reg),
        .sy      (sy_reg),
        .px      (dist_px),
        .py      (dist_py),
        .out_tag (d_tag),
        .dist_sq (d_val),
        .out_px  (d_px),
        .out_py  (d_py)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_DIM_RST;
            grid_height_reg <= GRID_DIM_RST;
            nbr_mode_reg    <= 1'b0;
            seed_shape_reg  <= 1'b0;
            point_limit_reg <= POINT_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_CFG_W-1:0];
                CFG_NBR_MODE:    nbr_mode_reg    <= cfg_data[0];
                CFG_SEED_SHAPE:  seed_shape_reg  <= cfg_data[0];
                CFG_POINT_LIMIT: point_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         nbr_mode_reg    <= nbr_mode_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            snap_reg         <= '0;
            scan_idx_reg     <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            hit_reg          <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            tag_d1_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tag_d1_reg <= issue_tag;

            // store count and snapshot
            if (accept && command == CMD_START)
            begin
                count_reg <= seed_shape_reg ? '0 : CW'(1);
                snap_reg  <= '0;
            end
            else if (accept && command == CMD_FRAME)
            begin
                snap_reg <= count_reg;
            end
            else if ((state_reg == ST_SEED && seed_go) || (state_reg == ST_COMMIT && found_reg))
            begin
                count_reg <= count_reg + CW'(1);
            end

            // scan address and neighbour position
            if (accept)
                scan_idx_reg <= '0;
            else if (state_reg == ST_SCAN)
                scan_idx_reg <= scan_idx_reg + AW'(1);

            if (state_reg == ST_DECIDE)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (state_reg == ST_NBR)
            begin
                if (col_reg == 2'd2)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 2'd1;
                end
                else
                begin
                    col_reg <= col_reg + 2'd1;
                end
            end

            // occupied and found flags
            if (accept)
                hit_reg <= 1'b0;
            else if (d_tag.vld && !d_tag.nbr && d_tag.in_snap && d_val == '0)
                hit_reg <= 1'b1;

            if (state_reg == ST_DECIDE)
                found_reg <= 1'b0;
            else if (d_tag.vld && d_tag.nbr && d_tag.use_pt && LW'(d_val) < nlim_reg)
                found_reg <= 1'b1;

            // output register
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        area_reg      <= (2*DW)'(w_dim) * (2*DW)'(h_dim);
        cand_x_d1_reg <= COORD_BITS'(cand_c);
        cand_y_d1_reg <= COORD_BITS'(cand_r);

        // word capture and immediate outcomes
        if (accept)
        begin
            sx_reg     <= sample_x;
            sy_reg     <= sample_y;
            best_d_reg <= '1;
            res_x_reg  <= '0;
            res_y_reg  <= '0;
            if (command != CMD_SAMPLE)
                res_status_reg <= STAT_DONE;
            else if (is_full)
                res_status_reg <= STAT_FULL;
            else if (out_of_range)
                res_status_reg <= STAT_RANGE;
            else
                res_status_reg <= STAT_NO_NBR;
        end

        // nearest stored point, first one wins ties
        if (d_tag.vld && !d_tag.nbr && d_val < best_d_reg)
        begin
            best_d_reg <= d_val;
            best_x_reg <= d_px;
            best_y_reg <= d_py;
        end

        // nearest neighbour candidate below the running limit
        if (state_reg == ST_DECIDE)
        begin
            nlim_reg <= {area_reg, 1'b0};
            if (hit_reg)
                res_status_reg <= STAT_OCCUPIED;
        end
        else if (d_tag.vld && d_tag.nbr && d_tag.use_pt && LW'(d_val) < nlim_reg)
        begin
            nlim_reg    <= LW'(d_val);
            nbest_x_reg <= d_px;
            nbest_y_reg <= d_py;
        end

        if (state_reg == ST_COMMIT)
        begin
            res_status_reg <= found_reg ? STAT_ATTACHED : STAT_NO_NBR;
            res_x_reg      <= found_reg ? nbest_x_reg : '0;
            res_y_reg      <= found_reg ? nbest_y_reg : '0;
        end

        // result word
        if (out_load)
        begin
            status_reg      <= res_status_reg;
            attached_x_reg  <= res_x_reg;
            attached_y_reg  <= res_y_reg;
            point_count_reg <= COUNT_OUT_W'(count_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign attached_x   = attached_x_reg;
    assign attached_y   = attached_y_reg;
    assign point_count  = point_count_reg;

endmodule

@@ sv/dla_checker.sv @@
// port-level checks of the aggregation block, bound to the top level
// depends on dla_pkg and assert_macros.svh
`include "assert_macros.svh"

module dla_checker #(
    parameter int COORD_BITS = dla_pkg::COORD_BITS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_valid,
    input logic                            item_ready,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [dla_pkg::STATUS_W-1:0]    status,
    input logic [COORD_BITS-1:0]           attached_x,
    input logic [COORD_BITS-1:0]           attached_y,
    input logic [dla_pkg::COUNT_OUT_W-1:0] point_count
);
    import dla_pkg::*;

    logic [1:0] pending_reg;

    // words taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(item_valid && item_ready)
                                       - 2'(result_valid && result_ready);
        end
    end

    // a waiting result holds until taken
    `ASSERT_HOLDS(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(status) && $stable(point_count))

    // no result without a word behind it
    `ASSERT_HOLDS(a_result_has_word, clk, rst_n, result_valid |-> pending_reg != 2'd0)

    // one word in work and one waiting at most
    `ASSERT_HOLDS(a_two_in_flight, clk, rst_n, pending_reg == 2'd2 |-> !item_ready)

    // coordinates only for an attachment
    `ASSERT_NEVER(a_coords_zero, clk, rst_n, result_valid && status != STAT_ATTACHED && (attached_x != '0 || attached_y != '0))

endmodule

bind aggregation_nearest_attach dla_checker #(
    .COORD_BITS (COORD_BITS)
) u_dla_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .attached_x   (attached_x),
    .attached_y   (attached_y),
    .point_count  (point_count)
);
